// File: hdl/binary_to_blanked_bcd_digits_unit_assert.svh
// assertion macros shared by the digit unit
`ifndef BINARY_TO_BLANKED_BCD_DIGITS_UNIT_ASSERT_SVH
`define BINARY_TO_BLANKED_BCD_DIGITS_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bbd_pkg.sv
package bbd_pkg;

  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 3;
  localparam int DIGIT_INDEX_W  = 3;
  localparam int CODE_W         = 4;
  localparam int SEG_W          = 7;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 16;
  localparam int DEFAULT_MAX_DIGITS = 6;

  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;

  // x / 10 == (x * 0xcccccccd) >> 35 for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hcccc_cccd;
  localparam int                 RECIP_SHIFT = 35;

  // segment a in bit 0 up to segment g in bit 6, blank for anything else
  function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    unique case (code)
      4'd0:    seg = 7'h3f;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5b;
      4'd3:    seg = 7'h4f;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6d;
      4'd6:    seg = 7'h7d;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7f;
      4'd9:    seg = 7'h6f;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// File: hdl/binary_to_blanked_bcd_digits_unit.sv
// binary to blanked bcd digits: each input item (a 32-bit unsigned value and a
// digit count, where 0 acts as 1 and counts above MAX_DIGITS saturate) yields
// one output item per digit, least significant first, carrying the digit index,
// the digit code (0-9, or 10 for a blanked leading zero) and the seven-segment
// pattern, with tlast on the most significant requested digit. digit 0 is always
// shown; zeros above the highest nonzero digit are blanked. a row of MAX_DIGITS
// identical cells peels off one decimal digit each (multiply by reciprocal of
// ten), and the serialiser register then takes all digits of the item. the output
// serialiser sends one digit per cycle while m_tready is high, each item holding
// the single output port for its digit_count digits (1 to MAX_DIGITS). new
// items keep entering the cell row until its full last cell waits on the serialiser
module binary_to_blanked_bcd_digits_unit
  import bbd_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0], digit_count[34:32]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // digit_index[2:0], digit_code[6:3],
                                            // segments[13:7]
  output logic                   m_tlast    // last_digit
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DIG_W = MAX_DIGITS * CODE_W;

  // input fields
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] digit_count;
  logic [CNT_W-1:0]   count_clamped;

  assign value       = s_tdata[VALUE_W-1:0];
  assign digit_count = s_tdata[VALUE_W +: COUNT_W];

  always_comb begin
    priority if (digit_count == '0) begin
      count_clamped = CNT_W'(1);
    end else if (int'(digit_count) > MAX_DIGITS) begin
      count_clamped = CNT_W'(MAX_DIGITS);
    end else begin
      count_clamped = CNT_W'(digit_count);
    end
  end

  // cell row, stage 0 is the input side
  logic               valid_c  [MAX_DIGITS+1];
  logic [VALUE_W-1:0] quot_c   [MAX_DIGITS+1];
  logic [CNT_W-1:0]   count_c  [MAX_DIGITS+1];
  logic [DIG_W-1:0]   digits_c [MAX_DIGITS+1];
  logic               advance;

  assign valid_c[0]  = s_tvalid;
  assign quot_c[0]   = value;
  assign count_c[0]  = count_clamped;
  assign digits_c[0] = '0;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    bbd_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .SLOT       (g),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .valid_in   (valid_c[g]),
      .quot_in    (quot_c[g]),
      .count_in   (count_c[g]),
      .digits_in  (digits_c[g]),
      .valid_out  (valid_c[g+1]),
      .quot_out   (quot_c[g+1]),
      .count_out  (count_c[g+1]),
      .digits_out (digits_c[g+1])
    );
  end

  // output serialiser
  logic              ser_valid;
  logic [IDX_W-1:0]  ser_idx;
  logic [CNT_W-1:0]  ser_count;
  logic [CODE_W-1:0] ser_codes [MAX_DIGITS];
  logic [CODE_W-1:0] codes_next [MAX_DIGITS];
  logic              ser_last;
  logic              out_take;
  logic              load;
  logic              row_full;

  assign row_full = valid_c[MAX_DIGITS];
  assign ser_last = (CNT_W'(ser_idx) + CNT_W'(1)) == ser_count;
  assign out_take = ser_valid && m_tready;
  assign load     = row_full && (!ser_valid || (out_take && ser_last));
  assign advance  = !row_full || load;
  assign s_tready = advance;

  // blank zeros from the top requested digit down to index 1
  always_comb begin
    logic seen;
    logic [CODE_W-1:0] d;
    seen = 1'b0;
    for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
      d = digits_c[MAX_DIGITS][i*CODE_W +: CODE_W];
      if (i < int'(count_c[MAX_DIGITS]) && d != '0) begin
        seen = 1'b1;
      end
      codes_next[i] = (i > 0 && !seen) ? BLANK_CODE : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx   <= '0;
    end else if (load) begin
      ser_valid <= 1'b1;
      ser_idx   <= '0;
    end else if (out_take) begin
      if (ser_last) begin
        ser_valid <= 1'b0;
      end else begin
        ser_idx <= ser_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_count <= count_c[MAX_DIGITS];
      ser_codes <= codes_next;
    end
  end

  // output fields
  logic [DIGIT_INDEX_W-1:0] digit_index;
  logic [CODE_W-1:0]        digit_code;
  logic [SEG_W-1:0]         segments;

  assign digit_index = DIGIT_INDEX_W'(ser_idx);
  assign digit_code  = ser_codes[ser_idx];
  assign segments    = seg_of(digit_code);

  assign m_tvalid = ser_valid;
  assign m_tlast  = ser_last;
  assign m_tdata  = OUT_TDATA_W'({segments, digit_code, digit_index});

  `include "binary_to_blanked_bcd_digits_unit_assert.svh"

  `BBD_ASSERT_NXT(a_idx_steps, out_take && !ser_last && !load,
    ser_valid && ser_idx == $past(ser_idx) + IDX_W'(1), "digit index did not step")
  `BBD_ASSERT_IMP(a_idx_in_count, ser_valid, CNT_W'(ser_idx) < ser_count,
    "digit index beyond count")
  `BBD_ASSERT_IMP(a_digit0_shown, ser_valid && ser_idx == '0, digit_code != BLANK_CODE,
    "digit 0 blanked")
  `BBD_ASSERT_IMP(a_stall_holds_row, ser_valid && !m_tready && s_tready, !row_full,
    "cell row moved into a stalled serialiser")

endmodule

// File: hdl/bbd_cell.sv
module bbd_cell
  import bbd_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
  parameter int SLOT       = 0,
  parameter int CNT_W      = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic [VALUE_W-1:0]           quot_in,
  input  logic [CNT_W-1:0]             count_in,
  input  logic [MAX_DIGITS*CODE_W-1:0] digits_in,
  output logic                         valid_out,
  output logic [VALUE_W-1:0]           quot_out,
  output logic [CNT_W-1:0]             count_out,
  output logic [MAX_DIGITS*CODE_W-1:0] digits_out
);

  logic [2*VALUE_W-1:0]           prod;
  logic [VALUE_W-1:0]             quot;
  logic [VALUE_W-1:0]             rem;
  logic [MAX_DIGITS*CODE_W-1:0]   digits_next;

  // divide by ten through the reciprocal, remainder by shift, add and subtract
  assign prod = (2*VALUE_W)'(quot_in) * (2*VALUE_W)'(RECIP_TEN);
  assign quot = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign rem  = quot_in - ((quot << 3) + (quot << 1));

  // own slot takes the new digit, the others pass through
  always_comb begin
    digits_next = digits_in;
    digits_next[SLOT*CODE_W +: CODE_W] = rem[CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_out   <= quot;
      count_out  <= count_in;
      digits_out <= digits_next;
    end
  end

endmodule

// File: dv/bcd_digit_checker.sv
module bcd_digit_checker
  import bbd_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0], digit_count[34:32]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // digit_index[2:0], digit_code[6:3],
                                            // segments[13:7]
  input  logic                   m_tlast,   // last_digit
  output int                     mismatch_count,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIGIT_INDEX_W-1:0] index;
    logic [CODE_W-1:0]        code;
    logic [SEG_W-1:0]         segments;
    logic                     last;
  } digit_t;

  // segment a in bit 0 up to segment g in bit 6
  localparam logic [SEG_W-1:0] DIGIT_PATTERN [10] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  digit_t expected_digits[$];
  int     errors = 0;

  assign outstanding    = expected_digits.size();
  assign mismatch_count = errors;

  // splits one value into its shown digits and queues them lsd first
  task automatic queue_digits_of(input logic [VALUE_W-1:0] value,
                                 input logic [COUNT_W-1:0] count_field);
    int               shown;
    int               top;
    logic [VALUE_W-1:0] rest;
    logic [CODE_W-1:0]  codes [MAX_DIGITS];
    digit_t           d;
    shown = (count_field == 0) ? 1 :
            (int'(count_field) > MAX_DIGITS) ? MAX_DIGITS : int'(count_field);
    rest = value;
    for (int i = 0; i < shown; i++) begin
      codes[i] = CODE_W'(rest % 10);
      rest     = rest / 10;
    end
    // leading zeros go blank, digit 0 never does
    top = shown - 1;
    while (top > 0 && codes[top] == 0) begin
      codes[top] = BLANK_CODE;
      top--;
    end
    for (int i = 0; i < shown; i++) begin
      d.index    = DIGIT_INDEX_W'(i);
      d.code     = codes[i];
      d.segments = (codes[i] == BLANK_CODE) ? '0 : DIGIT_PATTERN[codes[i]];
      d.last     = (i == shown - 1);
      expected_digits.push_back(d);
    end
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        queue_digits_of(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: COUNT_W]);
      if (m_tvalid && m_tready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected digit item: tdata %h tlast %b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          compare_field("digit_index", want.index, m_tdata[2:0]);
          compare_field("digit_code", want.code, m_tdata[6:3]);
          compare_field("segments", want.segments, m_tdata[13:7]);
          compare_field("last_digit", want.last, m_tlast);
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
module tb
  import bbd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no item moving on either side before the run is abandoned;
  // the longest receiver stall at 82 percent idling stays far below this
  localparam int STALL_LIMIT   = 2000;
  // an item passes the cell row and the serialiser register before its first digit appears
  localparam int DRAIN_CYCLES  = 2 * DEFAULT_MAX_DIGITS + 6;
  localparam int ITEMS_PER_PHASE = 150;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // value[31:0], digit_count[34:32]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // digit_index[2:0], digit_code[6:3],
                                          // segments[13:7]
  logic                   m_tlast;        // last_digit

  int mismatch_count;
  int outstanding;
  int tx_idle_pct = 28;
  int rx_idle_pct = 82;
  int quiet_cycles = 0;

  // powers of ten for values with a single nonzero digit
  int unsigned decade [6] = '{1, 10, 100, 1000, 10000, 100000};

  always #2 clk = ~clk;

  binary_to_blanked_bcd_digits_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  bcd_digit_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog: only cycles in which neither side moves an item count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offers one item, with random idle cycles in front of it; valid is only
  // lowered when a gap is actually taken, so back-to-back items keep it high
  task automatic send_number(input logic [VALUE_W-1:0] value,
                             input logic [COUNT_W-1:0] count);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - VALUE_W - COUNT_W){1'b0}}, count, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_numbers(input int items);
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    for (int n = 0; n < items; n++) begin
      // mix of magnitudes so that blanking of every depth turns up
      case ($urandom_range(0, 3))
        0:       value = $urandom;
        1:       value = $urandom_range(0, 999999);
        2:       value = $urandom >> $urandom_range(0, 31);
        default: value = $urandom_range(1, 9) * decade[$urandom_range(0, 5)];
      endcase
      // mostly legal counts, now and then a zero or an oversize count
      if ($urandom_range(0, 9) < 8)
        count = COUNT_W'($urandom_range(1, DEFAULT_MAX_DIGITS));
      else
        count = $urandom_range(0, 1) ? '0 : '1;
      send_number(value, count);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero at every count, including the zero and oversize counts
    for (int c = 0; c < 8; c++) send_number('0, COUNT_W'(c));
    // all ones, wider than any count
    send_number('1, 3'd6);
    send_number('1, 3'd7);
    send_number('1, 3'd1);
    // zero count with a nonzero value still shows just digit 0
    send_number(32'd47, 3'd0);
    // every digit code and pattern
    send_number(32'd987654, 3'd6);
    send_number(32'd3210, 3'd4);
    // interior zeros stay shown, only the leading ones blank
    send_number(32'd100000, 3'd6);
    send_number(32'd305, 3'd6);
    // values that fit the count, and digits above the count dropped, leaving zeros that then blank
    send_number(32'd1000000, 3'd6);
    send_number(32'd4000000000, 3'd5);
    send_number(32'd10, 3'd2);
    send_number(32'd7, 3'd3);
    send_number(32'd999999, 3'd6);
    send_number(32'd2147483648, 3'd7);

    // random: sender idles lightly, receiver heavily
    send_random_numbers(ITEMS_PER_PHASE);
    // the other way round
    tx_idle_pct = 82;
    rx_idle_pct = 28;
    send_random_numbers(ITEMS_PER_PHASE);
    // full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_numbers(ITEMS_PER_PHASE);
    s_tvalid <= 1'b0;

    // drain, then give any stray digit items time to show up
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
